### rtl/cst_pkg.sv
// Shared types, constants and character-class functions of the character stream tokenizer.
package cst_pkg;

    // Fixed field widths of the result word.
    localparam int KIND_W  = 4;
    localparam int INT_W   = 63;
    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 5;

    // Token kinds as they appear on the result port.
    localparam logic [KIND_W-1:0] KIND_INT    = 4'd0;
    localparam logic [KIND_W-1:0] KIND_IDENT  = 4'd1;
    localparam logic [KIND_W-1:0] KIND_DEF    = 4'd2;
    localparam logic [KIND_W-1:0] KIND_RETURN = 4'd3;
    localparam logic [KIND_W-1:0] KIND_LET    = 4'd4;
    localparam logic [KIND_W-1:0] KIND_LBRACE = 4'd5;
    localparam logic [KIND_W-1:0] KIND_RBRACE = 4'd6;
    localparam logic [KIND_W-1:0] KIND_LPAREN = 4'd7;
    localparam logic [KIND_W-1:0] KIND_RPAREN = 4'd8;
    localparam logic [KIND_W-1:0] KIND_COMMA  = 4'd9;
    localparam logic [KIND_W-1:0] KIND_SEMI   = 4'd10;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ     = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ     = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;

    // Keywords, left aligned in six characters.
    localparam logic [47:0] KW_DEF    = {"def", 24'h0};
    localparam logic [47:0] KW_RETURN = "return";
    localparam logic [47:0] KW_LET    = {"let", 24'h0};

    // Largest integer value; the accumulator saturates here.
    localparam logic [INT_W-1:0] INT_MAX = {INT_W{1'b1}};

    // Lexer mode held by the datapath.
    typedef enum logic [1:0] {
        MODE_INIT = 2'd0,
        MODE_INT  = 2'd1,
        MODE_WORD = 2'd2
    } t_lex_mode;

    // Source of the next result word.
    typedef enum logic [1:0] {
        OUT_INT   = 2'd0,
        OUT_KW    = 2'd1,
        OUT_PUNCT = 2'd2,
        OUT_IDENT = 2'd3
    } t_out_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     accept;
        logic     int_step;
        logic     word_step;
        logic     init_action;
        logic     mode_clear;
        logic     idx_clear;
        logic     idx_inc;
        logic     rd_issue;
        logic     out_load;
        t_out_sel out_sel;
        logic     out_last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_lex_mode mode;
        logic      digit;
        logic      alnum;
        logic      punct;
        logic      kw_hit;
        logic      idx_last;
        logic      out_free;
    } t_dp_stat;

    function automatic logic is_dec_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_start(input logic [CHAR_W-1:0] c);
        return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ)) ||
               (c == CH_UNDER);
    endfunction

    function automatic logic is_punct(input logic [CHAR_W-1:0] c);
        logic hit;
        case (c) inside
            CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_COMMA, CH_SEMI: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic [KIND_W-1:0] punct_kind(input logic [CHAR_W-1:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_COMMA:  k = KIND_COMMA;
            default:   k = KIND_SEMI;
        endcase
        return k;
    endfunction

    // Character at position pos (0 to 5) of a left-aligned keyword.
    function automatic logic [CHAR_W-1:0] kw_char(input logic [47:0] kw, input logic [2:0] pos);
        return kw[8*(5-pos) +: 8];
    endfunction

endpackage

### rtl/cst_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module cst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/cst_dp.sv
// Datapath of the tokenizer: character latch, integer accumulator, name store and result register.
module cst_dp #(
    parameter int MAX_IDENT_LEN = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cst_pkg::t_dp_cmd                 i_cmd,
    output cst_pkg::t_dp_stat                o_stat,
    input  logic [cst_pkg::CHAR_W-1:0]       i_in_char,
    input  logic                             i_stall,
    output logic                             o_valid,
    output logic [cst_pkg::KIND_W-1:0]       o_token_kind,
    output logic [cst_pkg::INT_W-1:0]        o_int_value,
    output logic                             o_int_saturated,
    output logic [cst_pkg::CHAR_W-1:0]       o_ident_char,
    output logic [cst_pkg::INDEX_W-1:0]      o_ident_index,
    output logic                             o_ident_end,
    output logic                             o_ident_truncated,
    output logic                             o_run_last
);

    localparam int LEN_W     = $clog2(MAX_IDENT_LEN + 1);
    localparam int AW        = $clog2(MAX_IDENT_LEN);
    localparam int INT_W_EXT = cst_pkg::INT_W + 4;

    logic [cst_pkg::CHAR_W-1:0] r_char;
    cst_pkg::t_lex_mode         r_mode;
    logic [cst_pkg::INT_W-1:0]  r_accum;
    logic                       r_int_ovf;
    logic [LEN_W-1:0]           r_name_len;
    logic                       r_name_ovf;
    logic                       r_def_ok;
    logic                       r_ret_ok;
    logic                       r_let_ok;
    logic [LEN_W-1:0]           r_idx;

    logic                         r_valid;
    logic [cst_pkg::KIND_W-1:0]   r_kind;
    logic [cst_pkg::INT_W-1:0]    r_int_value;
    logic                         r_int_sat;
    logic [cst_pkg::CHAR_W-1:0]   r_ident_char;
    logic [cst_pkg::INDEX_W-1:0]  r_ident_index;
    logic                         r_ident_end;
    logic                         r_ident_trunc;
    logic                         r_run_last;

    logic                         c_digit;
    logic                         c_start;
    logic                         c_punct;
    logic [3:0]                   digit_val;
    logic [INT_W_EXT-1:0]         acc_next;
    logic                         acc_sat;
    logic                         len_room;
    logic [LEN_W-1:0]             wr_pos;
    logic                         def_prev;
    logic                         ret_prev;
    logic                         let_prev;
    logic                         n_def_ok;
    logic                         n_ret_ok;
    logic                         n_let_ok;
    logic                         def_hit;
    logic                         ret_hit;
    logic                         let_hit;
    logic [cst_pkg::KIND_W-1:0]   kw_kind;
    logic                         idx_last;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [cst_pkg::CHAR_W-1:0]   ram_rdata;
    logic [LEN_W+cst_pkg::INDEX_W-1:0] idx_ext;

    // Class of the latched character.
    assign c_digit   = cst_pkg::is_dec_digit(r_char);
    assign c_start   = cst_pkg::is_start(r_char);
    assign c_punct   = cst_pkg::is_punct(r_char);
    assign digit_val = 4'(r_char - cst_pkg::CH_0);

    // Ten times the accumulator plus the new digit; any bit at or above bit 63 means saturation.
    assign acc_next = INT_W_EXT'({r_accum, 3'b000}) + INT_W_EXT'({r_accum, 1'b0}) +
                      INT_W_EXT'(digit_val);
    assign acc_sat  = |acc_next[INT_W_EXT-1:cst_pkg::INT_W];

    // Name store write position and keyword prefix tracking.
    assign len_room = r_name_len < LEN_W'(MAX_IDENT_LEN);
    assign wr_pos   = i_cmd.word_step ? r_name_len : '0;
    assign def_prev = i_cmd.word_step ? r_def_ok : 1'b1;
    assign ret_prev = i_cmd.word_step ? r_ret_ok : 1'b1;
    assign let_prev = i_cmd.word_step ? r_let_ok : 1'b1;

    assign n_def_ok = def_prev && ((wr_pos >= LEN_W'(3)) ||
                      (r_char == cst_pkg::kw_char(cst_pkg::KW_DEF, wr_pos[2:0])));
    assign n_ret_ok = ret_prev && ((wr_pos >= LEN_W'(6)) ||
                      (r_char == cst_pkg::kw_char(cst_pkg::KW_RETURN, wr_pos[2:0])));
    assign n_let_ok = let_prev && ((wr_pos >= LEN_W'(3)) ||
                      (r_char == cst_pkg::kw_char(cst_pkg::KW_LET, wr_pos[2:0])));

    // A truncated name never matches a keyword.
    assign def_hit = !r_name_ovf && (r_name_len == LEN_W'(3)) && r_def_ok;
    assign ret_hit = !r_name_ovf && (r_name_len == LEN_W'(6)) && r_ret_ok;
    assign let_hit = !r_name_ovf && (r_name_len == LEN_W'(3)) && r_let_ok;

    always_comb begin
        if (def_hit) begin
            kw_kind = cst_pkg::KIND_DEF;
        end else if (ret_hit) begin
            kw_kind = cst_pkg::KIND_RETURN;
        end else begin
            kw_kind = cst_pkg::KIND_LET;
        end
    end

    assign idx_last = (r_idx + LEN_W'(1)) == r_name_len;
    assign idx_ext  = {{cst_pkg::INDEX_W{1'b0}}, r_idx};

    // Name store.
    assign ram_we    = (i_cmd.word_step && len_room) || (i_cmd.init_action && c_start);
    assign ram_waddr = i_cmd.init_action ? '0 : r_name_len[AW-1:0];

    cst_ram #(
        .WIDTH (cst_pkg::CHAR_W),
        .DEPTH (MAX_IDENT_LEN)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_char),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Lexer state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= cst_pkg::MODE_INIT;
            r_accum    <= '0;
            r_int_ovf  <= 1'b0;
            r_name_len <= '0;
            r_name_ovf <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (i_cmd.int_step) begin
                if (acc_sat) begin
                    r_accum   <= cst_pkg::INT_MAX;
                    r_int_ovf <= 1'b1;
                end else begin
                    r_accum <= acc_next[cst_pkg::INT_W-1:0];
                end
            end
            if (i_cmd.word_step) begin
                if (len_room) begin
                    r_name_len <= r_name_len + LEN_W'(1);
                end else begin
                    r_name_ovf <= 1'b1;
                end
            end
            if (i_cmd.mode_clear) begin
                r_mode     <= cst_pkg::MODE_INIT;
                r_name_len <= '0;
                r_name_ovf <= 1'b0;
            end
            if (i_cmd.init_action) begin
                if (c_digit) begin
                    r_mode    <= cst_pkg::MODE_INT;
                    r_accum   <= cst_pkg::INT_W'(digit_val);
                    r_int_ovf <= 1'b0;
                end else if (c_start) begin
                    r_mode     <= cst_pkg::MODE_WORD;
                    r_name_len <= LEN_W'(1);
                    r_name_ovf <= 1'b0;
                end else begin
                    r_mode <= cst_pkg::MODE_INIT;
                end
            end
            if (i_cmd.out_load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload registers: character latch, keyword flags, read index and result word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_char <= i_in_char;
        end
        if ((i_cmd.word_step && len_room) || (i_cmd.init_action && c_start)) begin
            r_def_ok <= n_def_ok;
            r_ret_ok <= n_ret_ok;
            r_let_ok <= n_let_ok;
        end
        if (i_cmd.idx_clear) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + LEN_W'(1);
        end
        if (i_cmd.out_load) begin
            r_int_value   <= '0;
            r_int_sat     <= 1'b0;
            r_ident_char  <= '0;
            r_ident_index <= '0;
            r_ident_end   <= 1'b0;
            r_ident_trunc <= 1'b0;
            r_run_last    <= i_cmd.out_last;
            case (i_cmd.out_sel)
                cst_pkg::OUT_INT: begin
                    r_kind      <= cst_pkg::KIND_INT;
                    r_int_value <= r_accum;
                    r_int_sat   <= r_int_ovf;
                end
                cst_pkg::OUT_KW: begin
                    r_kind <= kw_kind;
                end
                cst_pkg::OUT_PUNCT: begin
                    r_kind <= cst_pkg::punct_kind(r_char);
                end
                default: begin
                    r_kind        <= cst_pkg::KIND_IDENT;
                    r_ident_char  <= ram_rdata;
                    r_ident_index <= idx_ext[cst_pkg::INDEX_W-1:0];
                    r_ident_end   <= idx_last;
                    r_ident_trunc <= r_name_ovf;
                end
            endcase
        end
    end

    // Status to the controller.
    assign o_stat.mode     = r_mode;
    assign o_stat.digit    = c_digit;
    assign o_stat.alnum    = c_digit || c_start;
    assign o_stat.punct    = c_punct;
    assign o_stat.kw_hit   = def_hit || ret_hit || let_hit;
    assign o_stat.idx_last = idx_last;
    assign o_stat.out_free = !r_valid || !i_stall;

    assign o_valid           = r_valid;
    assign o_token_kind      = r_kind;
    assign o_int_value       = r_int_value;
    assign o_int_saturated   = r_int_sat;
    assign o_ident_char      = r_ident_char;
    assign o_ident_index     = r_ident_index;
    assign o_ident_end       = r_ident_end;
    assign o_ident_truncated = r_ident_trunc;
    assign o_run_last        = r_run_last;

endmodule

### rtl/cst_ctrl.sv
// Controller state machine of the tokenizer: sequences accept, run handling and identifier output.
module cst_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  cst_pkg::t_dp_stat  i_stat,
    output cst_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_WORK = 3'd1,
        S_READ = 3'd2,
        S_SEND = 3'd3,
        S_INIT = 3'd4
    } t_state;

    t_state r_state;
    t_state n_state;

    // Initial-mode handling of the latched character; a punctuation token needs a free output.
    function automatic void init_step(input cst_pkg::t_dp_stat stat,
                                      inout cst_pkg::t_dp_cmd cmd, inout t_state nxt);
        if (stat.punct) begin
            if (stat.out_free) begin
                cmd.out_load    = 1'b1;
                cmd.out_sel     = cst_pkg::OUT_PUNCT;
                cmd.out_last    = 1'b1;
                cmd.init_action = 1'b1;
                nxt             = S_IDLE;
            end
        end else begin
            cmd.init_action = 1'b1;
            nxt             = S_IDLE;
        end
    endfunction

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_WORK;
                end
            end
            S_WORK: begin
                unique case (i_stat.mode)
                    cst_pkg::MODE_INT: begin
                        if (i_stat.digit) begin
                            o_cmd.int_step = 1'b1;
                            n_state        = S_IDLE;
                        end else if (i_stat.out_free) begin
                            o_cmd.out_load   = 1'b1;
                            o_cmd.out_sel    = cst_pkg::OUT_INT;
                            o_cmd.out_last   = !i_stat.punct;
                            o_cmd.mode_clear = 1'b1;
                            n_state          = S_INIT;
                        end
                    end
                    cst_pkg::MODE_WORD: begin
                        if (i_stat.alnum) begin
                            o_cmd.word_step = 1'b1;
                            n_state         = S_IDLE;
                        end else if (i_stat.kw_hit) begin
                            if (i_stat.out_free) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_sel    = cst_pkg::OUT_KW;
                                o_cmd.out_last   = !i_stat.punct;
                                o_cmd.mode_clear = 1'b1;
                                n_state          = S_INIT;
                            end
                        end else begin
                            o_cmd.idx_clear = 1'b1;
                            n_state         = S_READ;
                        end
                    end
                    default: begin
                        init_step(i_stat, o_cmd, n_state);
                    end
                endcase
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_SEND;
            end
            S_SEND: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = cst_pkg::OUT_IDENT;
                    o_cmd.out_last = i_stat.idx_last && !i_stat.punct;
                    o_cmd.idx_inc  = 1'b1;
                    if (i_stat.idx_last) begin
                        o_cmd.mode_clear = 1'b1;
                        n_state          = S_INIT;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_INIT: begin
                init_step(i_stat, o_cmd, n_state);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = r_state != S_IDLE;

endmodule

### rtl/char_stream_tokenizer.sv
// Top level of the character stream tokenizer: controller, datapath and checks.
//
// One 8-bit character enters per input word (i_valid, o_stall); tokens leave one
// result word at a time (o_valid, i_stall). Integer runs give one token with a
// 63-bit value saturating at 2^63-1; word runs give a keyword token or one result
// per stored identifier character, with index, end and truncation flags.
// Punctuation gives one token; whitespace and stray characters give nothing.
// o_run_last marks the final result word caused by an input character.
// A character that continues a run is accepted, then updates it; punctuation in
// the initial mode is accepted, then sent. A character that closes a run waits as
// needed for the output register and loads the run's result (an identifier reads
// and sends each stored character in turn from the registered name store), then
// is handled from the initial mode. Results appear in the output register in the
// cycle after they are formed. Only one character is in work at a time.
// Reset (synchronous, active low) returns to the initial mode and empties the
// output register. While i_stall is high the result word holds and the block
// waits at the next result it must send, stalling its input.
module char_stream_tokenizer #(
    parameter int MAX_IDENT_LEN = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [cst_pkg::CHAR_W-1:0]    i_in_char,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [cst_pkg::KIND_W-1:0]    o_token_kind,
    output logic [cst_pkg::INT_W-1:0]     o_int_value,
    output logic                          o_int_saturated,
    output logic [cst_pkg::CHAR_W-1:0]    o_ident_char,
    output logic [cst_pkg::INDEX_W-1:0]   o_ident_index,
    output logic                          o_ident_end,
    output logic                          o_ident_truncated,
    output logic                          o_run_last
);

    cst_pkg::t_dp_cmd  dp_cmd;
    cst_pkg::t_dp_stat dp_stat;

    cst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    cst_dp #(
        .MAX_IDENT_LEN (MAX_IDENT_LEN)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_stat            (dp_stat),
        .i_in_char         (i_in_char),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_token_kind      (o_token_kind),
        .o_int_value       (o_int_value),
        .o_int_saturated   (o_int_saturated),
        .o_ident_char      (o_ident_char),
        .o_ident_index     (o_ident_index),
        .o_ident_end       (o_ident_end),
        .o_ident_truncated (o_ident_truncated),
        .o_run_last        (o_run_last)
    );

    // An accepted character is always worked on before the next one is taken.
    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken again right after an accepted word");

    // A result is only formed when the output register can take it.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.out_load |-> dp_stat.out_free)
        else $error("result loaded over a waiting word");

    // A waiting result leaves only through a completed handshake.
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_valid) && $past(i_rst_n)) |-> $past(!i_stall))
        else $error("result word dropped while stalled");

endmodule

### dv/char_stream_tokenizer_tb.sv
// Self-checking testbench of the character stream tokenizer with a built-in token predictor.
module char_stream_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 8;
    localparam int MAX_IDENT    = 32;
    // Characters sent in the random phases; the directed rows bring the total to about 210.
    localparam int RAND_ITEMS   = 184;
    localparam int PHASES       = 4;
    localparam int DRAIN_CYCLES = 100;
    localparam int QUIET_LIMIT  = 2000;

    localparam logic [cst_pkg::CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [cst_pkg::CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [cst_pkg::CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [cst_pkg::CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [cst_pkg::CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [cst_pkg::CHAR_W-1:0] CH_TOP   = 8'hFF;

    // One result word as the block sends it.
    typedef struct packed {
        logic [cst_pkg::KIND_W-1:0]  kind;
        logic [cst_pkg::INT_W-1:0]   value;
        logic                        sat;
        logic [cst_pkg::CHAR_W-1:0]  ch;
        logic [cst_pkg::INDEX_W-1:0] idx;
        logic                        id_end;
        logic                        trunc;
        logic                        last;
    } t_token_word;

    // One row of the directed table; typed rows carry their result words.
    typedef struct {
        logic [cst_pkg::CHAR_W-1:0] ch;
        bit                         typed;
        int                         n;
        t_token_word                w0;
        t_token_word                w1;
    } t_stim_row;

    logic                        i_clk     = 1'b0;
    logic                        i_rst_n   = 1'b0;
    logic                        i_valid   = 1'b0;
    logic [cst_pkg::CHAR_W-1:0]  i_in_char = '0;
    logic                        i_stall   = 1'b0;
    logic                        o_stall;
    logic                        o_valid;
    logic [cst_pkg::KIND_W-1:0]  o_token_kind;
    logic [cst_pkg::INT_W-1:0]   o_int_value;
    logic                        o_int_saturated;
    logic [cst_pkg::CHAR_W-1:0]  o_ident_char;
    logic [cst_pkg::INDEX_W-1:0] o_ident_index;
    logic                        o_ident_end;
    logic                        o_ident_truncated;
    logic                        o_run_last;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int failures       = 0;
    int sent_chars     = 0;
    int quiet_cycles   = 0;

    t_token_word                expected_tokens[$];
    t_token_word                pred_words[$];
    t_token_word                want_word;
    logic [cst_pkg::CHAR_W-1:0] text_q[$];

    // Predictor state.
    cst_pkg::t_lex_mode         scan_mode = cst_pkg::MODE_INIT;
    logic [cst_pkg::INT_W-1:0]  acc_value = '0;
    logic                       acc_sat   = 1'b0;
    logic [cst_pkg::CHAR_W-1:0] id_chars [MAX_IDENT];
    int                         id_len    = 0;
    logic                       id_trunc  = 1'b0;

    char_stream_tokenizer u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_in_char         (i_in_char),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_token_kind      (o_token_kind),
        .o_int_value       (o_int_value),
        .o_int_saturated   (o_int_saturated),
        .o_ident_char      (o_ident_char),
        .o_ident_index     (o_ident_index),
        .o_ident_end       (o_ident_end),
        .o_ident_truncated (o_ident_truncated),
        .o_run_last        (o_run_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Character classes.
    function automatic bit char_digit(input logic [cst_pkg::CHAR_W-1:0] c);
        return c >= cst_pkg::CH_0 && c <= cst_pkg::CH_9;
    endfunction

    function automatic bit char_lead(input logic [cst_pkg::CHAR_W-1:0] c);
        return (c >= cst_pkg::CH_UA && c <= cst_pkg::CH_UZ) ||
               (c >= cst_pkg::CH_LA && c <= cst_pkg::CH_LZ) || c == cst_pkg::CH_UNDER;
    endfunction

    function automatic bit punct_token(input logic [cst_pkg::CHAR_W-1:0] c,
                                       output logic [cst_pkg::KIND_W-1:0] kind);
        punct_token = 1'b1;
        kind = cst_pkg::KIND_SEMI;
        case (c)
            cst_pkg::CH_LBRACE: kind = cst_pkg::KIND_LBRACE;
            cst_pkg::CH_RBRACE: kind = cst_pkg::KIND_RBRACE;
            cst_pkg::CH_LPAREN: kind = cst_pkg::KIND_LPAREN;
            cst_pkg::CH_RPAREN: kind = cst_pkg::KIND_RPAREN;
            cst_pkg::CH_COMMA:  kind = cst_pkg::KIND_COMMA;
            cst_pkg::CH_SEMI:   kind = cst_pkg::KIND_SEMI;
            default:            punct_token = 1'b0;
        endcase
    endfunction

    // A stored name counts as a keyword only when complete and untruncated.
    function automatic bit name_matches(input string kw);
        if (id_trunc || id_len != kw.len()) return 1'b0;
        for (int i = 0; i < kw.len(); i++) begin
            if (id_chars[i] != kw[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_token_word tok(input logic [cst_pkg::KIND_W-1:0] kind,
                                        input logic [cst_pkg::INT_W-1:0] value,
                                        input logic last);
        t_token_word w;
        w = '0;
        w.kind = kind;
        w.value = value;
        w.last = last;
        return w;
    endfunction

    function automatic t_stim_row step_row(input logic [cst_pkg::CHAR_W-1:0] c,
                                           input bit typed, input int n,
                                           input t_token_word w0, input t_token_word w1);
        t_stim_row r;
        r.ch = c;
        r.typed = typed;
        r.n = n;
        r.w0 = w0;
        r.w1 = w1;
        return r;
    endfunction

    // Work out the result words of one character and advance the predictor state.
    task automatic tokenize_char(input logic [cst_pkg::CHAR_W-1:0] c);
        t_token_word                w;
        logic [63:0]                digit;
        logic [cst_pkg::KIND_W-1:0] pk;
        pred_words.delete();
        w = '0;
        if (scan_mode == cst_pkg::MODE_INT) begin
            if (char_digit(c)) begin
                digit = 64'(c - cst_pkg::CH_0);
                if (64'(acc_value) > (64'(cst_pkg::INT_MAX) - digit) / 64'd10) begin
                    acc_value = cst_pkg::INT_MAX;
                    acc_sat = 1'b1;
                end else begin
                    acc_value = cst_pkg::INT_W'(64'(acc_value) * 64'd10 + digit);
                end
                return;
            end
            w.kind = cst_pkg::KIND_INT;
            w.value = acc_value;
            w.sat = acc_sat;
            pred_words = {pred_words, w};
            scan_mode = cst_pkg::MODE_INIT;
        end else if (scan_mode == cst_pkg::MODE_WORD) begin
            if (char_digit(c) || char_lead(c)) begin
                if (id_len < MAX_IDENT) begin
                    id_chars[id_len] = c;
                    id_len++;
                end else begin
                    id_trunc = 1'b1;
                end
                return;
            end
            if (name_matches("def")) begin
                pred_words = {pred_words, tok(cst_pkg::KIND_DEF, '0, 1'b0)};
            end else if (name_matches("return")) begin
                pred_words = {pred_words, tok(cst_pkg::KIND_RETURN, '0, 1'b0)};
            end else if (name_matches("let")) begin
                pred_words = {pred_words, tok(cst_pkg::KIND_LET, '0, 1'b0)};
            end else begin
                for (int i = 0; i < id_len; i++) begin
                    w = '0;
                    w.kind = cst_pkg::KIND_IDENT;
                    w.ch = id_chars[i];
                    w.idx = cst_pkg::INDEX_W'(i);
                    w.id_end = (i + 1 == id_len);
                    w.trunc = id_trunc;
                    pred_words = {pred_words, w};
                end
            end
            scan_mode = cst_pkg::MODE_INIT;
            id_len = 0;
            id_trunc = 1'b0;
        end

        // The character is handled again from the initial mode.
        if (char_digit(c)) begin
            scan_mode = cst_pkg::MODE_INT;
            acc_value = cst_pkg::INT_W'(c - cst_pkg::CH_0);
            acc_sat = 1'b0;
        end else if (char_lead(c)) begin
            scan_mode = cst_pkg::MODE_WORD;
            id_chars[0] = c;
            id_len = 1;
            id_trunc = 1'b0;
        end else if (punct_token(c, pk)) begin
            pred_words = {pred_words, tok(pk, '0, 1'b0)};
        end
        if (pred_words.size() > 0) pred_words[pred_words.size() - 1].last = 1'b1;
    endtask

    // Send one character word, then queue what it should produce.
    task automatic push_char(input logic [cst_pkg::CHAR_W-1:0] c, input bit typed,
                             input int n_typed, input t_token_word w0, input t_token_word w1);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_char <= c;
        do @(posedge i_clk); while (o_stall);
        tokenize_char(c);
        if (typed) begin
            pred_words.delete();
            if (n_typed > 0) pred_words = {pred_words, w0};
            if (n_typed > 1) pred_words = {pred_words, w1};
        end
        sent_chars++;
        foreach (pred_words[k]) expected_tokens = {expected_tokens, pred_words[k]};
    endtask

    // Random character sources.
    function automatic logic [cst_pkg::CHAR_W-1:0] rand_lead();
        int r;
        r = $urandom_range(52);
        if (r < 26) return cst_pkg::CH_UA + 8'(r);
        if (r < 52) return cst_pkg::CH_LA + 8'(r - 26);
        return cst_pkg::CH_UNDER;
    endfunction

    function automatic logic [cst_pkg::CHAR_W-1:0] rand_name_char();
        if ($urandom_range(4) == 0) return cst_pkg::CH_0 + 8'($urandom_range(9));
        return rand_lead();
    endfunction

    function automatic logic [cst_pkg::CHAR_W-1:0] rand_space();
        case ($urandom_range(3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [cst_pkg::CHAR_W-1:0] rand_punct();
        case ($urandom_range(5))
            0: return cst_pkg::CH_LBRACE;
            1: return cst_pkg::CH_RBRACE;
            2: return cst_pkg::CH_LPAREN;
            3: return cst_pkg::CH_RPAREN;
            4: return cst_pkg::CH_COMMA;
            default: return cst_pkg::CH_SEMI;
        endcase
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) text_q = {text_q, s[i]};
    endtask

    task automatic gen_int(input int len);
        for (int i = 0; i < len; i++) text_q = {text_q, cst_pkg::CH_0 + 8'($urandom_range(9))};
    endtask

    task automatic gen_ident(input int len);
        text_q = {text_q, rand_lead()};
        for (int i = 1; i < len; i++) text_q = {text_q, rand_name_char()};
    endtask

    // Mostly well-formed tokens with random content, some noise.
    task automatic gen_token();
        int sel;
        sel = $urandom_range(99);
        if (sel < 20) begin
            gen_int(($urandom_range(7) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 5));
        end else if (sel < 25) begin
            push_text($urandom_range(1) ? "9223372036854775807" : "9223372036854775808");
        end else if (sel < 45) begin
            case ($urandom_range(5))
                0: push_text("def");
                1: push_text("return");
                2: push_text("let");
                3: push_text("de");
                4: push_text("lets");
                default: push_text("Return");
            endcase
        end else if (sel < 65) begin
            gen_ident(($urandom_range(3) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8));
        end else if (sel < 82) begin
            text_q = {text_q, rand_punct()};
        end else if (sel < 92) begin
            text_q = {text_q, rand_space()};
        end else begin
            text_q = {text_q, 8'($urandom_range(255))};
        end
        if ($urandom_range(1)) text_q = {text_q, rand_space()};
    endtask

    // Receiver stall.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic check_field(input string field, input logic [cst_pkg::INT_W-1:0] want_v,
                               input logic [cst_pkg::INT_W-1:0] got_v);
        if (got_v !== want_v) begin
            failures++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
        end
    endtask

    // Compare each accepted result word with the oldest expected one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_tokens.size() == 0) begin
                failures++;
                $display("%0t ns: result word with nothing expected, expected none, got kind %0d",
                         $time, o_token_kind);
            end else begin
                want_word = expected_tokens.pop_front();
                check_field("token_kind", cst_pkg::INT_W'(want_word.kind),
                            cst_pkg::INT_W'(o_token_kind));
                check_field("int_value", want_word.value, o_int_value);
                check_field("int_saturated", cst_pkg::INT_W'(want_word.sat),
                            cst_pkg::INT_W'(o_int_saturated));
                check_field("ident_char", cst_pkg::INT_W'(want_word.ch),
                            cst_pkg::INT_W'(o_ident_char));
                check_field("ident_index", cst_pkg::INT_W'(want_word.idx),
                            cst_pkg::INT_W'(o_ident_index));
                check_field("ident_end", cst_pkg::INT_W'(want_word.id_end),
                            cst_pkg::INT_W'(o_ident_end));
                check_field("ident_truncated", cst_pkg::INT_W'(want_word.trunc),
                            cst_pkg::INT_W'(o_ident_truncated));
                check_field("run_last", cst_pkg::INT_W'(want_word.last),
                            cst_pkg::INT_W'(o_run_last));
            end
        end
    end

    // Watchdog on cycles in which no word moves on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial begin
        t_stim_row dir_rows[$];

        // Punctuation, stray extremes, integer from 0 and 9, keywords and a short name.
        dir_rows = {dir_rows, step_row(cst_pkg::CH_LBRACE, 1'b1, 1,
                                       tok(cst_pkg::KIND_LBRACE, '0, 1'b1), '0)};
        dir_rows = {dir_rows, step_row(cst_pkg::CH_RBRACE, 1'b1, 1,
                                       tok(cst_pkg::KIND_RBRACE, '0, 1'b1), '0)};
        dir_rows = {dir_rows, step_row(cst_pkg::CH_LPAREN, 1'b1, 1,
                                       tok(cst_pkg::KIND_LPAREN, '0, 1'b1), '0)};
        dir_rows = {dir_rows, step_row(cst_pkg::CH_RPAREN, 1'b1, 1,
                                       tok(cst_pkg::KIND_RPAREN, '0, 1'b1), '0)};
        dir_rows = {dir_rows, step_row(cst_pkg::CH_COMMA, 1'b1, 1,
                                       tok(cst_pkg::KIND_COMMA, '0, 1'b1), '0)};
        dir_rows = {dir_rows, step_row(cst_pkg::CH_SEMI, 1'b1, 1,
                                       tok(cst_pkg::KIND_SEMI, '0, 1'b1), '0)};
        dir_rows = {dir_rows, step_row(CH_NUL, 1'b1, 0, '0, '0)};
        dir_rows = {dir_rows, step_row(CH_TOP, 1'b1, 0, '0, '0)};
        dir_rows = {dir_rows, step_row(cst_pkg::CH_0, 1'b1, 0, '0, '0)};
        dir_rows = {dir_rows, step_row(cst_pkg::CH_9, 1'b1, 0, '0, '0)};
        dir_rows = {dir_rows, step_row(cst_pkg::CH_RPAREN, 1'b1, 2,
                                       tok(cst_pkg::KIND_INT, 63'd9, 1'b0),
                                       tok(cst_pkg::KIND_RPAREN, '0, 1'b1))};
        dir_rows = {dir_rows, step_row("l", 1'b0, 0, '0, '0)};
        dir_rows = {dir_rows, step_row("e", 1'b0, 0, '0, '0)};
        dir_rows = {dir_rows, step_row("t", 1'b0, 0, '0, '0)};
        dir_rows = {dir_rows, step_row(cst_pkg::CH_SEMI, 1'b1, 2,
                                       tok(cst_pkg::KIND_LET, '0, 1'b0),
                                       tok(cst_pkg::KIND_SEMI, '0, 1'b1))};
        dir_rows = {dir_rows, step_row("d", 1'b0, 0, '0, '0)};
        dir_rows = {dir_rows, step_row("e", 1'b0, 0, '0, '0)};
        dir_rows = {dir_rows, step_row("f", 1'b0, 0, '0, '0)};
        dir_rows = {dir_rows, step_row(CH_TAB, 1'b1, 1,
                                       tok(cst_pkg::KIND_DEF, '0, 1'b1), '0)};
        dir_rows = {dir_rows, step_row(cst_pkg::CH_UNDER, 1'b0, 0, '0, '0)};
        dir_rows = {dir_rows, step_row("Z", 1'b0, 0, '0, '0)};
        dir_rows = {dir_rows, step_row(cst_pkg::CH_9, 1'b0, 0, '0, '0)};
        dir_rows = {dir_rows, step_row(CH_CR, 1'b0, 0, '0, '0)};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r])
            push_char(dir_rows[r].ch, dir_rows[r].typed, dir_rows[r].n, dir_rows[r].w0,
                      dir_rows[r].w1);

        // Long names above and at the buffer size and a saturating integer first.
        gen_ident(36);
        text_q = {text_q, CH_SPACE};
        gen_ident(MAX_IDENT);
        text_q = {text_q, cst_pkg::CH_COMMA};
        gen_int(21);
        text_q = {text_q, cst_pkg::CH_SEMI};

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            sent_chars = 0;
            while (sent_chars < RAND_ITEMS / PHASES) begin
                if (text_q.size() == 0) gen_token();
                push_char(text_q.pop_front(), 1'b0, 0, '0, '0);
            end
            // Hold the input until every result word of this phase has been taken.
            i_valid <= 1'b0;
            do @(posedge i_clk); while (expected_tokens.size() != 0);
        end

        // Close any open run so that its token is checked too.
        push_char(cst_pkg::CH_SEMI, 1'b0, 0, '0, '0);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_tokens.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### files.f
rtl/cst_pkg.sv
rtl/cst_ram.sv
rtl/cst_dp.sv
rtl/cst_ctrl.sv
rtl/char_stream_tokenizer.sv
dv/char_stream_tokenizer_tb.sv
